[hdl/plc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// plc_pkg: shared types and constants of the positional list engine
// Sizes, operation and status codes, and the broadcast record seen by the
// cells of the list.
// ----------------------------------------------------------------------------
package plc_pkg;

    // Storage size and derived widths
    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int POS_W    = 5;
    localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
    localparam int DATA_W   = 32;

    // Operation codes
    typedef enum logic [2:0] {
        OP_INS_TAIL = 3'd0,
        OP_DEL_TAIL = 3'd1,
        OP_INS_HEAD = 3'd2,
        OP_DEL_HEAD = 3'd3,
        OP_INS_AT   = 3'd4,
        OP_DEL_AT   = 3'd5
    } op_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_DONE         = 2'd0,
        ST_NOT_POSSIBLE = 2'd1,
        ST_FULL         = 2'd2
    } status_t;

    // Command broadcast to every cell in the cycle an item is accepted
    typedef struct packed {
        logic              ins;
        logic              del;
        logic [IDX_W-1:0]  idx;
        logic [DATA_W-1:0] value;
    } plc_bcast_t;

endpackage
`default_nettype wire

[hdl/plc_cell.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// plc_cell: one slot of the list
// Holds one entry. On insert it takes its left neighbor or the new value,
// on delete it takes its right neighbor; it drives its entry on the tap
// when the broadcast index names it.
// ----------------------------------------------------------------------------
module plc_cell
    import plc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic [IDX_W-1:0]  my_idx,
    input  wire plc_bcast_t        bcast,
    input  wire logic [DATA_W-1:0] left_data,
    input  wire logic [DATA_W-1:0] right_data,
    output logic [DATA_W-1:0]      data,
    output logic [DATA_W-1:0]      tap
);

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;
    logic              hit;
    logic              above;

    assign hit   = (my_idx == bcast.idx);
    assign above = (my_idx > bcast.idx);

    // Pick the next entry: shift right, load, shift left or hold
    always_comb
    begin
        data_next = data_reg;
        if (bcast.ins)
        begin
            if (above)
                data_next = left_data;
            else if (hit)
                data_next = bcast.value;
        end
        else if (bcast.del)
        begin
            if (above || hit)
                data_next = right_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;
    // Drive the entry only when this slot is addressed
    assign tap  = hit ? data_reg : '0;

endmodule
`default_nettype wire

[hdl/positional_list_engine.sv]
// Each accepted item's result is registered in the output register.
// Throughput: one item per cycle when not stalled; every cell shifts, loads or holds
// in the same cycle, so the row of cells never stalls the input.
// Input stalls only while a finished result waits and the output is stalled.
// Reset clears the entry count and the output valid; entries are not cleared.
`default_nettype none
// ----------------------------------------------------------------------------
// positional_list_engine: bounded ordered list of signed 32-bit values
// Decodes head, tail and positional inserts and deletes against the entry
// count and drives a row of shifting cells; one result per item.
// ----------------------------------------------------------------------------
module positional_list_engine
    import plc_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [2:0]         opcode,
    input  wire logic [POS_W-1:0]   position,
    input  wire logic signed [31:0] value,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [31:0]      removed_value,
    output logic [1:0]              status,
    output logic [4:0]              entry_count
);

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              out_valid_reg;
    logic [DATA_W-1:0] removed_reg;
    logic [DATA_W-1:0] removed_next;
    status_t           status_reg;
    status_t           status_next;
    logic [4:0]        entry_count_reg;

    logic              accept;
    logic              full;
    logic              empty;
    logic              ins_ok;
    logic              del_ok;
    logic [IDX_W-1:0]  idx;
    logic [CMP_W-1:0]  pos_ext;
    logic [CMP_W-1:0]  cnt_ext;
    plc_bcast_t        bcast;

    logic [DATA_W-1:0] cell_data [CAPACITY];
    logic [DATA_W-1:0] cell_tap  [CAPACITY];
    logic [DATA_W-1:0] tap_or;

    // Hold the input only while a result waits and cannot leave
    assign in_stall = out_valid_reg & out_stall;
    assign accept   = in_valid & ~in_stall;

    assign full    = (count_reg == CNT_W'(CAPACITY));
    assign empty   = (count_reg == '0);
    assign pos_ext = CMP_W'(position);
    assign cnt_ext = CMP_W'(count_reg);

    // Decode the operation against the current count
    always_comb
    begin
        ins_ok      = 1'b0;
        del_ok      = 1'b0;
        idx         = '0;
        status_next = ST_NOT_POSSIBLE;
        unique case (op_t'(opcode))
            OP_INS_TAIL:
            begin
                if (full)
                    status_next = ST_FULL;
                else
                begin
                    ins_ok = 1'b1;
                    idx    = IDX_W'(count_reg);
                end
            end
            OP_DEL_TAIL:
            begin
                if (!empty)
                begin
                    del_ok = 1'b1;
                    idx    = IDX_W'(count_reg - 1'b1);
                end
            end
            OP_INS_HEAD:
            begin
                if (full)
                    status_next = ST_FULL;
                else
                    ins_ok = 1'b1;
            end
            OP_DEL_HEAD:
            begin
                if (!empty)
                    del_ok = 1'b1;
            end
            OP_INS_AT:
            begin
                if (full)
                    status_next = ST_FULL;
                else if ((pos_ext != '0) && (pos_ext <= cnt_ext + 1'b1))
                begin
                    ins_ok = 1'b1;
                    idx    = IDX_W'(pos_ext - 1'b1);
                end
            end
            OP_DEL_AT:
            begin
                if ((pos_ext != '0) && (pos_ext <= cnt_ext))
                begin
                    del_ok = 1'b1;
                    idx    = IDX_W'(pos_ext - 1'b1);
                end
            end
            default:
            begin
                status_next = ST_NOT_POSSIBLE;
            end
        endcase
        if (ins_ok || del_ok)
            status_next = ST_DONE;
    end

    // Broadcast the command to the cells only for an accepted item
    assign bcast.ins   = accept & ins_ok;
    assign bcast.del   = accept & del_ok;
    assign bcast.idx   = idx;
    assign bcast.value = DATA_W'(value);

    // Row of cells, each wired to its neighbors
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [DATA_W-1:0] left_in;
        logic [DATA_W-1:0] right_in;

        if (i == 0)
        begin : g_first
            assign left_in = '0;
        end
        else
        begin : g_mid_left
            assign left_in = cell_data[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_in = '0;
        end
        else
        begin : g_mid_right
            assign right_in = cell_data[i+1];
        end

        plc_cell u_cell (
            .clk        (clk),
            .my_idx     (IDX_W'(i)),
            .bcast      (bcast),
            .left_data  (left_in),
            .right_data (right_in),
            .data       (cell_data[i]),
            .tap        (cell_tap[i])
        );
    end

    // Gather the addressed entry from the taps
    always_comb
    begin
        tap_or = '0;
        for (int i = 0; i < CAPACITY; i++)
            tap_or = tap_or | cell_tap[i];
    end

    assign removed_next = del_ok ? tap_or : '0;

    // Advance the count
    always_comb
    begin
        count_next = count_reg;
        if (ins_ok)
            count_next = count_reg + 1'b1;
        else if (del_ok)
            count_next = count_reg - 1'b1;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                count_reg <= count_next;
            if (accept)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            removed_reg     <= removed_next;
            status_reg      <= status_next;
            entry_count_reg <= 5'(count_next);
        end
    end

    assign out_valid     = out_valid_reg;
    assign removed_value = removed_reg;
    assign status        = status_reg;
    assign entry_count   = entry_count_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        accept && ins_ok |=> count_reg == $past(count_reg) + 1'b1)
        else $error("accepted insert did not grow the list");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status_reg == ST_FULL |->
            count_reg == CNT_W'(CAPACITY) && removed_reg == '0)
        else $error("full status reported while not full");
`endif

endmodule
`default_nettype wire

[tb/plc_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// plc_checker: list shadow and result comparison for the list engine
// Watches both channels, replays every accepted item on a shadow copy of the
// list, queues the result it should produce and compares each result leaving
// the engine with the oldest queued one.
// ----------------------------------------------------------------------------
module plc_checker
    import plc_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic               in_stall,
    input  wire logic [2:0]         opcode,
    input  wire logic [POS_W-1:0]   position,
    input  wire logic signed [31:0] value,
    input  wire logic               out_valid,
    input  wire logic               out_stall,
    input  wire logic signed [31:0] removed_value,
    input  wire logic [1:0]         status,
    input  wire logic [4:0]         entry_count,
    output int                      mismatches,
    output int                      outstanding
);

    typedef struct packed {
        logic signed [DATA_W-1:0] removed;
        status_t                  status;
        logic [4:0]               count;
    } list_result_t;

    // Shadow of the list contents, head at index zero
    logic signed [DATA_W-1:0] shadow_list [CAPACITY];
    int                       shadow_len;
    list_result_t             pending_results [$];

    // Apply one operation to the shadow list and return the result it gives
    function automatic list_result_t apply_list_op(input logic [2:0] op,
                                                   input logic [POS_W-1:0] pos,
                                                   input logic signed [DATA_W-1:0] val);
        list_result_t res;
        int           slot;
        logic         is_ins;
        logic         is_del;
        res.removed = '0;
        res.status  = ST_NOT_POSSIBLE;
        slot        = 0;
        is_ins      = 1'b0;
        is_del      = 1'b0;
        case (op_t'(op))
            OP_INS_TAIL: begin is_ins = 1'b1; slot = shadow_len;      end
            OP_DEL_TAIL: begin is_del = 1'b1; slot = shadow_len - 1;  end
            OP_INS_HEAD: begin is_ins = 1'b1; slot = 0;               end
            OP_DEL_HEAD: begin is_del = 1'b1; slot = 0;               end
            OP_INS_AT:   begin is_ins = 1'b1; slot = int'(pos) - 1;   end
            OP_DEL_AT:   begin is_del = 1'b1; slot = int'(pos) - 1;   end
            default: ;
        endcase
        // Full store wins over a bad position
        if (is_ins) begin
            if (shadow_len >= CAPACITY)
                res.status = ST_FULL;
            else if (slot >= 0 && slot <= shadow_len) begin
                for (int i = shadow_len; i > slot; i--)
                    shadow_list[i] = shadow_list[i-1];
                shadow_list[slot] = val;
                shadow_len++;
                res.status = ST_DONE;
            end
        end
        else if (is_del) begin
            if (slot >= 0 && slot < shadow_len) begin
                res.removed = shadow_list[slot];
                for (int i = slot; i < shadow_len - 1; i++)
                    shadow_list[i] = shadow_list[i+1];
                shadow_len--;
                res.status = ST_DONE;
            end
        end
        res.count = 5'(shadow_len);
        return res;
    endfunction

    // Count a mismatch; print only the first few
    function automatic void flag_mismatch(input string field, input longint want,
                                          input longint got);
        if (mismatches < 10)
            $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, field, want, got);
        mismatches++;
    endfunction

    // Check leaving results first, then queue the prediction for the new item
    always @(posedge clk or negedge rst_n) begin
        list_result_t want;
        if (!rst_n) begin
            shadow_len = 0;
            pending_results.delete();
            mismatches  = 0;
            outstanding = 0;
        end
        else begin
            if (out_valid && !out_stall) begin
                if (pending_results.size() == 0)
                    flag_mismatch("unexpected result, entry_count", -1, entry_count);
                else begin
                    want = pending_results.pop_front();
                    if (removed_value !== want.removed)
                        flag_mismatch("removed_value", want.removed, removed_value);
                    if (status !== want.status)
                        flag_mismatch("status", want.status, status);
                    if (entry_count !== want.count)
                        flag_mismatch("entry_count", want.count, entry_count);
                end
            end
            if (in_valid && !in_stall)
                pending_results.push_back(apply_list_op(opcode, position, value));
            outstanding = pending_results.size();
        end
    end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the positional list engine
// Drives directed corner items, then a long run of random inserts, deletes
// and spare opcodes biased to sweep the list between empty and full, with
// random gaps, stalls, a long output hold-off and a full drain pause.
// ----------------------------------------------------------------------------
module tb_top;
    import plc_pkg::*;

    localparam logic [2:0] OP_SPARE_6     = 3'd6;
    localparam logic [2:0] OP_SPARE_7     = 3'd7;
    localparam int         RANDOM_ITEMS   = 1500;
    localparam int         HOLDOFF_CYCLES = 60;
    localparam int         IDLE_PCT       = 38;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid;
    logic               in_stall;
    logic [2:0]         opcode;
    logic [POS_W-1:0]   position;
    logic signed [31:0] value;
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] removed_value;
    logic [1:0]         status;
    logic [4:0]         entry_count;

    int   mismatches;
    int   outstanding;
    logic send_gaps;
    logic recv_steady;
    int   holdoffs_asked;

    always #4 clk = ~clk;

    positional_list_engine dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .opcode        (opcode),
        .position      (position),
        .value         (value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .removed_value (removed_value),
        .status        (status),
        .entry_count   (entry_count)
    );

    plc_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .opcode        (opcode),
        .position      (position),
        .value         (value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .removed_value (removed_value),
        .status        (status),
        .entry_count   (entry_count),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    // Offer one item, after a random gap when gaps are on, and hold it until accepted
    task automatic send_item(input logic [2:0] op, input logic [POS_W-1:0] pos,
                             input logic [31:0] val);
        while (send_gaps && ($urandom_range(0, 99) < IDLE_PCT))
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode   <= op;
        position <= pos;
        value    <= val;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Drop valid and wait until every queued result has left
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // Pick a value, leaning on the extremes now and then
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 19))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h0000_0000;
            default: return $urandom();
        endcase
    endfunction

    // Receiver: random stalls, steady stretches, and counted hold-offs
    initial
    begin : recv_side
        int hold_left;
        int holdoffs_served;
        hold_left       = 0;
        holdoffs_served = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (holdoffs_served != holdoffs_asked)
            begin
                holdoffs_served = holdoffs_asked;
                hold_left       = HOLDOFF_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (recv_steady)
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // Hard stop on a hung run
    initial
    begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        int fill_pct;
        int pick;
        in_valid <= 1'b0;
        opcode   <= OP_INS_TAIL;
        position <= '0;
        value    <= '0;
        send_gaps      = 1'b1;
        recv_steady    = 1'b0;
        holdoffs_asked = 0;
        fill_pct       = 50;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Refused operations on an empty list and spare opcodes
        send_item(OP_DEL_TAIL, 5'd1, 32'h0);
        send_item(OP_DEL_HEAD, 5'd31, 32'h0);
        send_item(OP_DEL_AT, 5'd1, 32'h0);
        send_item(OP_SPARE_6, 5'd0, 32'hFFFF_FFFF);
        send_item(OP_SPARE_7, 5'd31, 32'h1234_5678);
        send_item(OP_INS_AT, 5'd0, 32'h0000_0001);
        send_item(OP_INS_AT, 5'd2, 32'h0000_0002);

        // Build a short list through every insert flavor, one past the end
        send_item(OP_INS_AT, 5'd1, 32'h8000_0000);
        send_item(OP_INS_TAIL, 5'd0, 32'h7FFF_FFFF);
        send_item(OP_INS_HEAD, 5'd31, 32'hFFFF_FFFF);
        send_item(OP_INS_AT, 5'd4, 32'h0000_0000);
        send_item(OP_DEL_AT, 5'd5, 32'h0);
        send_item(OP_INS_AT, 5'd2, 32'h5555_5555);

        // Fill to capacity at random positions
        for (int k = 5; k < CAPACITY; k++)
            send_item(OP_INS_AT, 5'($urandom_range(1, k + 1)), $urandom());

        // Full store, full beating a bad position, deletes at the ends by position
        send_item(OP_INS_TAIL, 5'd0, 32'hAAAA_AAAA);
        send_item(OP_INS_AT, 5'd0, 32'h0F0F_0F0F);
        send_item(OP_DEL_AT, 5'd17, 32'h0);
        send_item(OP_DEL_AT, 5'd16, 32'h0);
        send_item(OP_DEL_AT, 5'd1, 32'h0);

        // Random operations, biased in phases to sweep between empty and full
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 64 == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       fill_pct = 20;
                    1:       fill_pct = 50;
                    default: fill_pct = 80;
                endcase
            end
            // Long output hold-off while the sender keeps pushing
            if (i == 300)
            begin
                send_gaps = 1'b0;
                holdoffs_asked++;
            end
            if (i == 380)
                send_gaps = 1'b1;
            if (i == 700)
                drain_results();
            if (i == 900)
            begin
                send_gaps   = 1'b0;
                recv_steady = 1'b1;
            end
            if (i == 1150)
            begin
                send_gaps   = 1'b1;
                recv_steady = 1'b0;
            end

            pick = $urandom_range(0, 99);
            if (pick < 6)
                send_item(pick < 3 ? OP_SPARE_6 : OP_SPARE_7, 5'($urandom()), pick_value());
            else if ($urandom_range(0, 99) < fill_pct)
            begin
                case ($urandom_range(0, 2))
                    0:       send_item(OP_INS_TAIL, 5'($urandom()), pick_value());
                    1:       send_item(OP_INS_HEAD, 5'($urandom()), pick_value());
                    default: send_item(OP_INS_AT,
                                       ($urandom_range(0, 99) < 85) ? 5'($urandom_range(1, 17))
                                                                    : 5'($urandom()),
                                       pick_value());
                endcase
            end
            else
            begin
                case ($urandom_range(0, 2))
                    0:       send_item(OP_DEL_TAIL, 5'($urandom()), pick_value());
                    1:       send_item(OP_DEL_HEAD, 5'($urandom()), pick_value());
                    default: send_item(OP_DEL_AT,
                                       ($urandom_range(0, 99) < 85) ? 5'($urandom_range(1, 17))
                                                                    : 5'($urandom()),
                                       pick_value());
                endcase
            end
        end

        // Let the last results out, then give the verdict
        drain_results();
        repeat (8) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
